// ===== rtl/core/gpio_pkg.sv =====
// Shared types, codes and helpers for the GPIO port with pin interrupts.
`timescale 1ns / 1ps

package gpio_pkg;

    // Fixed field widths of the port words
    localparam int PORT_W        = 32;
    localparam int PIN_IDX_W     = 5;
    localparam int MODE_W        = 3;
    localparam int CMD_W         = 3;
    localparam int PIN_COUNT_DEF = 32;

    // Command codes carried in the cmd field
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_SET      = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_TOGGLE   = 3'd3,
        CMD_DIR      = 3'd4,
        CMD_IRQ_MODE = 3'd5,
        CMD_CLR_FLAG = 3'd6,
        CMD_READ     = 3'd7
    } t_cmd;

    // Per-pin interrupt modes; codes six and seven are rejected on write
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 3'd0,
        MODE_LOW  = 3'd1,
        MODE_RISE = 3'd2,
        MODE_FALL = 3'd3,
        MODE_BOTH = 3'd4,
        MODE_HIGH = 3'd5
    } t_mode;

    // Input word
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [PIN_IDX_W-1:0] pin_index;
        logic [MODE_W-1:0]    mode_value;
        logic [PORT_W-1:0]    pin_mask;
        logic [PORT_W-1:0]    pin_levels;
    } t_gpio_in;

    // Result word
    typedef struct packed {
        logic [PORT_W-1:0] read_data;
        logic [PORT_W-1:0] drive_levels;
        logic [PORT_W-1:0] direction_bits;
        logic [PORT_W-1:0] flag_bits;
        logic              irq;
        logic              status;
    } t_gpio_out;

    // Low pin_count bits set, for pin counts from 1 to PORT_W
    function automatic logic [PORT_W-1:0] port_mask(input int pin_count);
        logic [PORT_W:0] full;
        full = ((PORT_W+1)'(1) << pin_count) - (PORT_W+1)'(1);
        return full[PORT_W-1:0];
    endfunction

    // Interrupt condition of one pin given its mode, new and stored sample
    function automatic logic mode_hit(input logic [MODE_W-1:0] mode,
                                      input logic now, input logic prev);
        logic hit;
        case (mode)
            MODE_LOW:  hit = ~now;
            MODE_RISE: hit = now & ~prev;
            MODE_FALL: hit = ~now & prev;
            MODE_BOTH: hit = now ^ prev;
            MODE_HIGH: hit = now;
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/core/gpio_in_reg.sv =====
// Input register stage: holds one accepted word until the core takes it.
`timescale 1ns / 1ps

module gpio_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gpio_pkg::t_gpio_in i_word,
    output logic               o_valid,
    input  logic               i_take,
    output gpio_pkg::t_gpio_in o_word
);
    import gpio_pkg::*;

    logic     r_valid;
    t_gpio_in r_word;

    // Free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== rtl/core/gpio_exec.sv =====
// Port state and the single-pass update of outputs, direction, modes and flags.
`timescale 1ns / 1ps

module gpio_exec #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  gpio_pkg::t_gpio_in  i_word,
    input  logic                i_space,
    output logic                o_fire,
    output gpio_pkg::t_gpio_out o_res
);
    import gpio_pkg::*;

    localparam logic [PORT_W-1:0] PortMask = port_mask(PIN_COUNT);

    logic [PORT_W-1:0] r_out, n_out;
    logic [PORT_W-1:0] r_dir, n_dir;
    logic [PORT_W-1:0] r_prev, n_prev;
    logic [PORT_W-1:0] r_flag, n_flag;
    logic [MODE_W-1:0] r_mode [PIN_COUNT];

    logic [PORT_W-1:0] w_hits;
    logic [PORT_W-1:0] w_mask;
    logic [PORT_W-1:0] w_levels;
    logic [PORT_W-1:0] w_pbit;
    logic [PORT_W-1:0] w_read;
    logic              w_pin_ok;
    logic              w_mode_we;
    logic              w_status;

    assign o_fire   = i_valid && i_space;
    assign w_mask   = i_word.pin_mask & PortMask;
    assign w_levels = i_word.pin_levels & PortMask;
    assign w_pbit   = PORT_W'(1) << i_word.pin_index;
    assign w_pin_ok = {1'b0, i_word.pin_index} < (PIN_IDX_W+1)'(PIN_COUNT);

    // Per-pin edge and level detection against the stored sample
    for (genvar p = 0; p < PORT_W; p++) begin : g_hit
        if (p < PIN_COUNT) begin : g_live
            assign w_hits[p] = mode_hit(r_mode[p], w_levels[p], r_prev[p]);
        end else begin : g_dead
            assign w_hits[p] = 1'b0;
        end
    end

    // Command decode and next state
    always_comb begin
        n_out     = r_out;
        n_dir     = r_dir;
        n_prev    = r_prev;
        n_flag    = r_flag;
        w_read    = '0;
        w_status  = 1'b0;
        w_mode_we = 1'b0;
        case (t_cmd'(i_word.cmd))
            CMD_TICK: begin
                n_flag = r_flag | w_hits;
                n_prev = w_levels;
            end
            CMD_SET: begin
                n_out = r_out | w_mask;
            end
            CMD_CLEAR: begin
                n_out = r_out & ~w_mask;
            end
            CMD_TOGGLE: begin
                n_out = r_out ^ w_mask;
            end
            CMD_DIR: begin
                if (w_pin_ok) begin
                    n_dir = i_word.mode_value[0] ? (r_dir | w_pbit) : (r_dir & ~w_pbit);
                end
            end
            CMD_IRQ_MODE: begin
                if (i_word.mode_value > MODE_HIGH) begin
                    w_status = 1'b1;
                end else if (w_pin_ok) begin
                    w_mode_we = 1'b1;
                    n_flag    = r_flag & ~w_pbit;
                end
            end
            CMD_CLR_FLAG: begin
                n_flag = r_flag & ~w_mask;
            end
            CMD_READ: begin
                w_read = r_prev;
            end
            default: begin
            end
        endcase
    end

    // Result word reflects state after this item
    always_comb begin
        o_res.read_data      = w_read;
        o_res.drive_levels   = n_out;
        o_res.direction_bits = n_dir;
        o_res.flag_bits      = n_flag;
        o_res.irq            = |n_flag;
        o_res.status         = w_status;
    end

    // Port registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out  <= '0;
            r_dir  <= '0;
            r_prev <= '0;
            r_flag <= '0;
        end else if (o_fire) begin
            r_out  <= n_out;
            r_dir  <= n_dir;
            r_prev <= n_prev;
            r_flag <= n_flag;
        end
    end

    // Interrupt mode per pin
    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_mode
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mode[p] <= MODE_OFF;
            end else if (o_fire && w_mode_we && (i_word.pin_index == PIN_IDX_W'(p))) begin
                r_mode[p] <= i_word.mode_value;
            end
        end
    end

endmodule

// ===== rtl/core/gpio_out_reg.sv =====
// Result register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module gpio_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_space,
    input  gpio_pkg::t_gpio_out i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output gpio_pkg::t_gpio_out o_word
);
    import gpio_pkg::*;

    logic      r_valid;
    t_gpio_out r_word;

    // Room when empty or when the held result is taken this cycle
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_space) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== rtl/core/gpio_port_with_pin_interrupts.sv =====
// Top level of the GPIO port with set/clear/toggle outputs and pin interrupts.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   command: a sample tick with pin levels, or a register access (set, clear,
//   toggle outputs, pin direction, pin interrupt mode, flag clear, read).
//   Output channel (o_out_valid / i_out_ready / o_out_word) returns exactly
//   one result word per command, in order: read data, output levels,
//   direction, flags, irq and status after that command.
//   Path: a word accepted into the input register waits there until the result
//   register has room, passes through the combinational state update and is
//   loaded into the result register, from which the receiver takes it.
//   Throughput: one word per cycle while the receiver keeps taking results;
//   the state update between the input and result registers is combinational.
//   Reset (synchronous, active low) clears outputs, directions (all inputs),
//   interrupt modes (all off), the stored sample and all flags, and empties
//   both registers.
//   When the receiver stalls, the result register holds its word, the held
//   input word waits, and o_in_ready drops once both are occupied; no word
//   is lost or repeated.
module gpio_port_with_pin_interrupts #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gpio_pkg::t_gpio_in  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gpio_pkg::t_gpio_out o_out_word
);
    import gpio_pkg::*;

    logic      w_in_valid;
    t_gpio_in  w_in_word;
    logic      w_fire;
    logic      w_space;
    t_gpio_out w_res;

    // Input register
    gpio_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (w_in_valid),
        .i_take  (w_fire),
        .o_word  (w_in_word)
    );

    // Port state and command execution
    gpio_exec #(
        .PIN_COUNT (PIN_COUNT)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_word  (w_in_word),
        .i_space (w_space),
        .o_fire  (w_fire),
        .o_res   (w_res)
    );

    // Result register
    gpio_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .o_space (w_space),
        .i_word  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// ===== rtl/core/gpio_chk.sv =====
// Port-level checker for the GPIO port, bound to the top level.
`timescale 1ns / 1ps

module gpio_chk #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gpio_pkg::t_gpio_out o_out_word
);
    import gpio_pkg::*;

    localparam logic [PORT_W-1:0] PortMask = port_mask(PIN_COUNT);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // irq tracks the flag word
    a_irq_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.irq == (|o_out_word.flag_bits)))
        else $error("irq disagrees with flags");

    // A rejected mode write is never a read
    a_status_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status) |-> (o_out_word.read_data == '0))
        else $error("rejected mode write returned read data");

    // Pins at or beyond PIN_COUNT stay quiet
    a_unused_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((o_out_word.drive_levels | o_out_word.direction_bits |
                           o_out_word.flag_bits | o_out_word.read_data) & ~PortMask) == '0))
        else $error("activity on pins beyond the port");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind gpio_port_with_pin_interrupts gpio_chk #(
    .PIN_COUNT (PIN_COUNT)
) u_gpio_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
